// ===== rtl/rmsn_pkg.sv =====
// Shared types and constants of the int8 RMS-norm row core.
// Depends on nothing; every module of the core imports it.
`default_nettype none
package rmsn_pkg;

    localparam int LANES         = 8;
    localparam int MAX_ROW_WORDS = 64;
    localparam int WORD_AW       = $clog2(MAX_ROW_WORDS);
    localparam int WORD_CW       = WORD_AW + 1;
    localparam int LANE_DW       = 8 * LANES;
    localparam int PROD_W        = 16;
    localparam int SUM_W         = 24;
    localparam int ELEM_W        = $clog2(LANES * MAX_ROW_WORDS) + 1;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WORDS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_IN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_NORM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_OUT  = 3'd4;

    typedef struct packed {
        logic [63:0] x_lanes;
        logic [63:0] w_lanes;
    } in_item_t;

    typedef struct packed {
        logic [63:0] y_lanes;
        logic        last_in_row;
        logic        last_row;
    } out_item_t;

    // Per-row coefficients handed to every lane unit
    typedef struct packed {
        logic [63:0] gain;        // g * scale_out
        logic [31:0] scale_norm;
    } row_coef_t;

endpackage
`default_nettype wire

// ===== rtl/rmsn_root.sv =====
// Row gain unit: g = isqrt(floor(n * 2^54 / sum)), zero when sum is zero.
// Serial restoring divider followed by a digit-by-digit square root; uses rmsn_pkg.
`default_nettype none
module rmsn_root (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [rmsn_pkg::ELEM_W-1:0] elem_count,
    input  wire logic [rmsn_pkg::SUM_W-1:0]  square_sum,
    output logic                           done,
    output logic [31:0]                    gain
);
    import rmsn_pkg::*;

    typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} root_state_t;

    root_state_t        state_reg;
    logic [5:0]         cnt_reg;
    logic [63:0]        num_reg;
    logic [SUM_W-1:0]   den_reg;
    logic [SUM_W-1:0]   rem_reg;
    logic               zero_reg;
    logic [63:0]        v_reg;
    logic [63:0]        r_reg;
    logic [63:0]        bit_reg;
    logic               done_reg;
    logic [31:0]        gain_reg;

    logic [SUM_W:0]     rem_sh;
    logic               q_bit;
    logic [SUM_W-1:0]   rem_next;
    logic [63:0]        num_next;
    logic [63:0]        trial;
    logic               take;
    logic [63:0]        v_next;
    logic [63:0]        r_next;

    // One quotient bit per cycle
    always_comb begin
        rem_sh   = {rem_reg, num_reg[63]};
        q_bit    = rem_sh >= {1'b0, den_reg};
        rem_next = q_bit ? SUM_W'(rem_sh - {1'b0, den_reg}) : rem_sh[SUM_W-1:0];
        num_next = {num_reg[62:0], q_bit};
    end

    // One root bit per cycle
    always_comb begin
        trial  = r_reg + bit_reg;
        take   = v_reg >= trial;
        v_next = take ? v_reg - trial : v_reg;
        r_next = take ? (r_reg >> 1) + bit_reg : r_reg >> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end else begin
            // Pulse done on the last root step
            done_reg <= (state_reg == R_SQRT) && (cnt_reg == '0);
            unique case (state_reg)
                R_IDLE: begin
                    if (start) begin
                        num_reg   <= {(64 - ELEM_W)'(0), elem_count} << 54;
                        den_reg   <= square_sum;
                        zero_reg  <= square_sum == '0;
                        rem_reg   <= '0;
                        cnt_reg   <= 6'd63;
                        state_reg <= R_DIV;
                    end
                end
                R_DIV: begin
                    rem_reg <= rem_next;
                    num_reg <= num_next;
                    if (cnt_reg == '0) begin
                        v_reg     <= num_next;
                        r_reg     <= '0;
                        bit_reg   <= 64'd1 << 62;
                        cnt_reg   <= 6'd31;
                        state_reg <= R_SQRT;
                    end else begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                R_SQRT: begin
                    v_reg   <= v_next;
                    r_reg   <= r_next;
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == '0) begin
                        gain_reg  <= zero_reg ? 32'd0 : r_next[31:0];
                        state_reg <= R_IDLE;
                    end
                end
                default: state_reg <= R_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign gain = gain_reg;

endmodule
`default_nettype wire

// ===== rtl/rmsn_lane.sv =====
// Lane scaler: one stored product x*w to a saturated int8 result.
// t = floor(|p| * gain / (scale_norm * 2^26)) by a serial divider; uses rmsn_pkg.
`default_nettype none
module rmsn_lane (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [rmsn_pkg::PROD_W-1:0] prod,
    input  wire rmsn_pkg::row_coef_t         coef,
    output logic                             done,
    output logic [7:0]                       y
);
    import rmsn_pkg::*;

    typedef enum logic [2:0] {L_IDLE, L_LO, L_HI, L_DIV, L_FIN} lane_state_t;

    lane_state_t  state_reg;
    logic [15:0]  mag_reg;
    logic         neg_reg;
    logic [47:0]  plo_reg;
    logic [79:0]  rem_reg;
    logic [66:0]  dsh_reg;
    logic         ovf_reg;
    logic [9:0]   t_reg;
    logic [3:0]   cnt_reg;
    logic         done_reg;
    logic [7:0]   y_reg;

    logic [15:0]  mag_in;
    logic [47:0]  phi;
    logic [79:0]  num;
    logic         ovf;
    logic         q_bit;
    logic [10:0]  q_pos;
    logic [9:0]   q_neg;
    logic [7:0]   y_next;

    assign mag_in = prod[PROD_W-1] ? 16'(-prod) : prod;

    // Combine the two partial products and flag a quotient beyond ten bits
    always_comb begin
        phi = mag_reg * coef.gain[63:32];
        num = {phi, 32'd0} + {32'd0, plo_reg};
        ovf = (num != '0) && (num[79:36] >= {12'd0, coef.scale_norm});
    end

    // A zero remainder yields no more quotient bits, even for a zero divisor
    assign q_bit = (rem_reg != '0) && (rem_reg >= {13'd0, dsh_reg});

    // Round positives half away from zero, negatives to (t - 1) >> 1, then saturate
    always_comb begin
        q_pos = (11'(t_reg) + 11'd1) >> 1;
        q_neg = (t_reg == '0) ? 10'd0 : (t_reg - 10'd1) >> 1;
        if (!neg_reg) begin
            y_next = (q_pos > 11'd127) ? 8'd127 : q_pos[7:0];
        end else begin
            y_next = (q_neg > 10'd128) ? 8'h80 : 8'(-q_neg[7:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        mag_reg   <= mag_in;
                        neg_reg   <= prod[PROD_W-1];
                        done_reg  <= 1'b0;
                        state_reg <= L_LO;
                    end
                end
                L_LO: begin
                    plo_reg   <= mag_reg * coef.gain[31:0];
                    state_reg <= L_HI;
                end
                L_HI: begin
                    rem_reg   <= num;
                    ovf_reg   <= ovf;
                    dsh_reg   <= {3'd0, coef.scale_norm, 32'd0} << 3;
                    t_reg     <= '0;
                    cnt_reg   <= 4'd9;
                    state_reg <= L_DIV;
                end
                L_DIV: begin
                    if (ovf_reg) begin
                        t_reg     <= '1;
                        state_reg <= L_FIN;
                    end else begin
                        if (q_bit) begin
                            rem_reg <= rem_reg - {13'd0, dsh_reg};
                        end
                        t_reg   <= {t_reg[8:0], q_bit};
                        dsh_reg <= dsh_reg >> 1;
                        cnt_reg <= cnt_reg - 4'd1;
                        if (cnt_reg == '0) begin
                            state_reg <= L_FIN;
                        end
                    end
                end
                L_FIN: begin
                    y_reg     <= y_next;
                    done_reg  <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule
`default_nettype wire

// ===== rtl/int8_rms_norm_row_core.sv =====
// Top level of the int8 RMS-norm row core: row memory, row sequencer, output register.
// Depends on rmsn_pkg, rmsn_root and rmsn_lane.
//
// A row of W input words is taken one item per cycle while s_ready is high;
// each word's eight products x*w go into the row memory and the sum of x*x
// accumulates. After the last word the gain unit runs (64-step divider,
// then 32-step square root), one multiply forms the row gain, and the row
// is replayed: each result word passes through the memory read and the
// eight parallel lane scalers with their ten-step dividers. No input item
// is accepted during replay; the final result word may still wait in the
// output register while the next row loads. No clearing pass is needed.
`default_nettype none
module int8_rms_norm_row_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire rmsn_pkg::in_item_t             s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output rmsn_pkg::out_item_t                 m_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rmsn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rmsn_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rmsn_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD, ST_ROOT_GO, ST_ROOT, ST_COEF, ST_READ, ST_LANE_GO, ST_LANE, ST_EMIT
    } seq_state_t;

    // Configuration registers
    logic [6:0]  row_words_reg;
    logic [15:0] num_rows_reg;
    logic [31:0] scale_norm_reg;
    logic [31:0] scale_out_reg;

    seq_state_t             state_reg;
    logic [WORD_AW-1:0]     word_idx_reg;
    logic [WORD_AW-1:0]     rd_word_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [15:0]            row_idx_reg;
    logic                   last_row_reg;
    logic [31:0]            g_reg;
    row_coef_t              coef_reg;
    logic                   m_valid_reg;
    out_item_t              m_data_reg;

    // Row memory: one word of LANES products per entry
    logic [LANES*PROD_W-1:0] mem [MAX_ROW_WORDS];
    logic [LANES*PROD_W-1:0] rd_data_reg;
    logic [LANES*PROD_W-1:0] wr_data;
    logic                    mem_we;

    logic                    accept;
    logic [SUM_W-1:0]        sq_total;
    logic [6:0]              words_eff;
    logic [15:0]             rows_eff;
    logic                    row_end;
    logic                    is_last_row;
    logic [ELEM_W-1:0]       elem_count;
    logic                    root_start;
    logic                    root_done;
    logic [31:0]             root_gain;
    logic                    lane_start;
    logic [LANES-1:0]        lane_done;
    logic [LANE_DW-1:0]      lane_y;
    logic                    out_free;
    logic                    last_word;
    logic                    emit_now;

    assign accept    = s_valid && s_ready;
    assign s_ready   = state_reg == ST_LOAD;
    assign cfg_ready = 1'b1;

    // Take configuration writes; scale_in cancels out of the result, so drop its writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_words_reg  <= 7'd1;
            num_rows_reg   <= 16'd1;
            scale_norm_reg <= 32'd65536;
            scale_out_reg  <= 32'd65536;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_ROW_WORDS)  row_words_reg  <= cfg_data[6:0];
            if (cfg_index == REG_NUM_ROWS)   num_rows_reg   <= cfg_data[15:0];
            if (cfg_index == REG_SCALE_NORM) scale_norm_reg <= cfg_data;
            if (cfg_index == REG_SCALE_OUT)  scale_out_reg  <= cfg_data;
        end
    end

    // Lane products and squares of the incoming word
    always_comb begin
        logic signed [7:0]  xl;
        logic signed [7:0]  wl;
        logic signed [15:0] pr;
        logic signed [15:0] sq;
        sq_total = '0;
        wr_data  = '0;
        for (int k = 0; k < LANES; k++) begin
            xl = s_data.x_lanes[8*k +: 8];
            wl = s_data.w_lanes[8*k +: 8];
            pr = xl * wl;
            sq = xl * xl;
            wr_data[PROD_W*k +: PROD_W] = pr;
            sq_total = sq_total + SUM_W'(sq);
        end
    end

    // Effective row length and row count
    always_comb begin
        if (row_words_reg == '0) begin
            words_eff = 7'd1;
        end else if (row_words_reg > 7'(MAX_ROW_WORDS)) begin
            words_eff = 7'(MAX_ROW_WORDS);
        end else begin
            words_eff = row_words_reg;
        end
        rows_eff    = (num_rows_reg == '0) ? 16'd1 : num_rows_reg;
        row_end     = (WORD_CW'(word_idx_reg) + WORD_CW'(1)) >= WORD_CW'(words_eff);
        is_last_row = row_idx_reg >= rows_eff - 16'd1;
        elem_count  = ELEM_W'((WORD_CW'(word_idx_reg) + WORD_CW'(1)) * LANES);
    end

    assign mem_we = accept;

    // Write on load, read for replay; the sequencer keeps the two phases apart
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[word_idx_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_word_reg];
    end

    assign root_start = state_reg == ST_ROOT_GO;
    assign lane_start = state_reg == ST_LANE_GO;
    assign out_free   = !m_valid_reg || m_ready;
    assign last_word  = rd_word_reg == word_idx_reg;
    assign emit_now   = (state_reg == ST_EMIT) && out_free;

    rmsn_root u_root (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (root_start),
        .elem_count (elem_count),
        .square_sum (sum_reg),
        .done       (root_done),
        .gain       (root_gain)
    );

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        rmsn_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (lane_start),
            .prod    (rd_data_reg[PROD_W*k +: PROD_W]),
            .coef    (coef_reg),
            .done    (lane_done[k]),
            .y       (lane_y[8*k +: 8])
        );
    end

    // Row sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            word_idx_reg <= '0;
            rd_word_reg  <= '0;
            sum_reg      <= '0;
            row_idx_reg  <= '0;
            last_row_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // Load a new result word, or drop the one just taken
            if (emit_now) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (accept) begin
                        sum_reg <= sum_reg + sq_total;
                        if (row_end) begin
                            last_row_reg <= is_last_row;
                            state_reg    <= ST_ROOT_GO;
                        end else begin
                            word_idx_reg <= word_idx_reg + WORD_AW'(1);
                        end
                    end
                end
                ST_ROOT_GO: state_reg <= ST_ROOT;
                ST_ROOT: begin
                    if (root_done) begin
                        g_reg       <= root_gain;
                        rd_word_reg <= '0;
                        state_reg   <= ST_COEF;
                    end
                end
                ST_COEF: begin
                    coef_reg.gain       <= g_reg * scale_out_reg;
                    coef_reg.scale_norm <= scale_norm_reg;
                    state_reg           <= ST_READ;
                end
                ST_READ:    state_reg <= ST_LANE_GO;
                ST_LANE_GO: state_reg <= ST_LANE;
                ST_LANE: begin
                    if (&lane_done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_data_reg.y_lanes      <= lane_y;
                        m_data_reg.last_in_row  <= last_word;
                        m_data_reg.last_row     <= last_row_reg;
                        if (last_word) begin
                            word_idx_reg <= '0;
                            sum_reg      <= '0;
                            row_idx_reg  <= last_row_reg ? 16'd0 : row_idx_reg + 16'd1;
                            state_reg    <= ST_LOAD;
                        end else begin
                            rd_word_reg <= rd_word_reg + WORD_AW'(1);
                            state_reg   <= ST_READ;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // Gain unit finishes only while the sequencer waits for it
    a_root_done_in_root: assert property (@(posedge aclk) disable iff (!aresetn)
        root_done |-> state_reg == ST_ROOT)
        else $error("gain unit finished outside its phase");

    // Every lane unit has finished before a word is emitted
    a_lanes_done_at_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> &lane_done)
        else $error("lane unit still busy at emit");

    // Replay never passes the last loaded word
    a_replay_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> rd_word_reg <= word_idx_reg)
        else $error("replay beyond row end");
`endif

endmodule
`default_nettype wire
